FILE: rtl/i2cseq_pkg.sv
// Shared types and codes for the I2C master transaction sequencer.
// No dependencies; the FIFO, core and top-level files import this package.
`default_nettype none

package i2cseq_pkg;

  // Default sizes of the transaction queue and the outgoing byte FIFO.
  localparam int QUEUE_DEPTH_DEF   = 8;
  localparam int TX_FIFO_DEPTH_DEF = 64;

  // Command codes of an input beat.
  localparam logic [1:0] CMD_ENQUEUE      = 2'd0;
  localparam logic [1:0] CMD_PUSH_BYTE    = 2'd1;
  localparam logic [1:0] CMD_ENGINE_EVENT = 2'd2;
  localparam logic [1:0] CMD_ERROR_EVENT  = 2'd3;

  // Bit positions in event_flags.
  localparam int EV_START_SENT = 0;
  localparam int EV_ADDR_ACKED = 1;
  localparam int EV_TX_EMPTY   = 2;
  localparam int EV_BYTE_DONE  = 3;
  localparam int EV_RX_READY   = 4;
  localparam int EV_BUS_ERROR  = 5;

  // ACK control codes.
  localparam logic [1:0] ACK_LEAVE   = 2'd0;
  localparam logic [1:0] ACK_ENABLE  = 2'd1;
  localparam logic [1:0] ACK_DISABLE = 2'd2;

  // Transaction end codes.
  localparam logic [1:0] END_NONE = 2'd0;
  localparam logic [1:0] END_DONE = 2'd1;
  localparam logic [1:0] END_FAIL = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] addr;
    logic [7:0] len_out;
    logic [7:0] len_in;
    logic [7:0] data;
    logic [5:0] event_flags;
  } in_item_t;

  typedef struct packed {
    logic       write_dr;
    logic [7:0] dr_value;
    logic       set_start;
    logic       set_stop;
    logic [1:0] ack_ctl;
    logic       clear_errors;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [1:0] txn_end;
    logic [7:0] txn_id;
    logic [1:0] phase;
    logic       rejected;
  } out_item_t;

  // One queued transaction.
  typedef struct packed {
    logic [7:0] id;
    logic [7:0] len_in;
    logic [7:0] len_out;
    logic [7:0] addr;
  } txn_entry_t;

  // Per-cycle operation request for a FIFO.
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_op_t;

endpackage

`default_nettype wire

FILE: rtl/i2cseq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module i2cseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                 wr_data,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
  output      logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/i2cseq_fifo.sv
// Circular FIFO on a registered-read RAM, with the head entry always presented on front.
// Depends on i2cseq_pkg and i2cseq_ram.
`default_nettype none

module i2cseq_fifo
  import i2cseq_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire fifo_op_t                     op,
  input  wire logic [$clog2(DEPTH+1)-1:0]   drop,
  input  wire logic [WIDTH-1:0]             wr_data,
  output      logic [$clog2(DEPTH+1)-1:0]   count,
  output      logic [WIDTH-1:0]             front
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0]    head;
  logic [AW-1:0]    head_next;
  logic [AW-1:0]    tail;
  logic [AW-1:0]    tail_next;
  logic [CW-1:0]    count_next;
  logic [CW-1:0]    advance;
  logic [CW:0]      head_sum;
  logic [WIDTH-1:0] rd_data;
  logic             bypass;
  logic [WIDTH-1:0] bypass_data;

  // Head moves by one on a pop, or by the drop count; the sum stays below twice the depth.
  always_comb begin
    advance  = drop + CW'(op.pop);
    head_sum = (CW+1)'(head) + (CW+1)'(advance);
    if (head_sum >= (CW+1)'(DEPTH)) begin
      head_next = AW'(head_sum - (CW+1)'(DEPTH));
    end else begin
      head_next = AW'(head_sum);
    end
    if (!op.push) begin
      tail_next = tail;
    end else if (tail == AW'(DEPTH - 1)) begin
      tail_next = '0;
    end else begin
      tail_next = tail + AW'(1);
    end
    count_next = count + CW'(op.push) - CW'(op.pop) - drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      bypass <= 1'b0;
    end else begin
      head   <= head_next;
      tail   <= tail_next;
      count  <= count_next;
      bypass <= op.push && (tail == head_next);
    end
    bypass_data <= wr_data;
  end

  // The RAM is read at the next head every cycle, so rd_data tracks the head entry;
  // a write to that same slot in the same cycle is forwarded around the RAM.
  i2cseq_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (op.push),
    .wr_addr (tail),
    .wr_data (wr_data),
    .rd_addr (head_next),
    .rd_data (rd_data)
  );

  assign front = bypass ? bypass_data : rd_data;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fifo count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    op.pop |-> (count != '0 || op.push))
    else $error("pop from empty fifo");
  a_drop_bound: assert property (@(posedge clk) disable iff (rst)
    drop != '0 |-> (drop <= count && !op.pop && !op.push))
    else $error("drop exceeds fifo contents or overlaps another operation");
`endif

endmodule

`default_nettype wire

FILE: rtl/i2cseq_core.sv
// Transaction state, queue, byte FIFO and the combinational step logic of the sequencer.
// Depends on i2cseq_pkg and i2cseq_fifo.
`default_nettype none

module i2cseq_core
  import i2cseq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int TX_FIFO_DEPTH = TX_FIFO_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire in_item_t  item,
  output      out_item_t result
);

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int TCW = $clog2(TX_FIFO_DEPTH + 1);
  localparam int DW  = (TCW > 8) ? TCW : 8;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEND = 2'd1,
    PH_RECV = 2'd2
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] cur_addr;
  logic [7:0] cur_addr_next;
  logic [7:0] remain_out;
  logic [7:0] remain_out_next;
  logic [7:0] remain_in;
  logic [7:0] remain_in_next;
  logic [7:0] cur_id;
  logic [7:0] cur_id_next;
  logic [7:0] next_id;
  logic [7:0] next_id_next;

  fifo_op_t   q_op;
  fifo_op_t   q_cmd;
  fifo_op_t   tx_op;
  fifo_op_t   tx_cmd;
  logic [TCW-1:0] tx_drop;
  logic [TCW-1:0] tx_drop_cmd;
  logic [QCW-1:0] q_count;
  logic [TCW-1:0] tx_count;
  txn_entry_t q_front;
  txn_entry_t q_wr;
  txn_entry_t start_entry;
  logic [7:0] tx_front;
  logic [DW-1:0] remain_ext;
  logic [DW-1:0] count_ext;

  assign q_wr = '{id: next_id, len_in: item.len_in, len_out: item.len_out, addr: item.addr};

  always_comb begin
    result          = '0;
    phase_next      = phase;
    cur_addr_next   = cur_addr;
    remain_out_next = remain_out;
    remain_in_next  = remain_in;
    cur_id_next     = cur_id;
    next_id_next    = next_id;
    q_op            = '0;
    tx_op           = '0;
    tx_drop         = '0;
    remain_ext      = DW'(remain_out);
    count_ext       = DW'(tx_count);
    start_entry     = q_front;

    unique case (item.cmd)
      CMD_ENQUEUE: begin
        if (q_count >= QCW'(QUEUE_DEPTH)) begin
          result.rejected = 1'b1;
        end else begin
          q_op.push      = 1'b1;
          result.txn_id  = next_id;
          next_id_next   = next_id + 8'd1;
        end
      end
      CMD_PUSH_BYTE: begin
        if (tx_count >= TCW'(TX_FIFO_DEPTH)) begin
          result.rejected = 1'b1;
        end else begin
          tx_op.push = 1'b1;
        end
      end
      CMD_ENGINE_EVENT: begin
        unique case (phase)
          PH_SEND: begin
            priority if (item.event_flags[EV_START_SENT]) begin
              result.write_dr = 1'b1;
              result.dr_value = cur_addr;
            end else if (item.event_flags[EV_ADDR_ACKED]) begin
              // The first data byte goes out on the following tx-empty event.
            end else if (item.event_flags[EV_TX_EMPTY]) begin
              if (remain_out != 8'd0) begin
                // An empty FIFO sends a zero byte instead of stalling the bus.
                result.write_dr = 1'b1;
                if (tx_count != '0) begin
                  result.dr_value = tx_front;
                  tx_op.pop       = 1'b1;
                end
                remain_out_next = remain_out - 8'd1;
              end else if (item.event_flags[EV_BYTE_DONE]) begin
                if (remain_in != 8'd0) begin
                  result.set_start = 1'b1;
                  phase_next       = PH_RECV;
                end else begin
                  result.set_stop = 1'b1;
                  result.txn_end  = END_DONE;
                  result.txn_id   = cur_id;
                  phase_next      = PH_IDLE;
                end
              end
            end else begin
              // Other events leave the write phase where it is.
            end
          end
          PH_RECV: begin
            priority if (item.event_flags[EV_START_SENT]) begin
              result.write_dr = 1'b1;
              result.dr_value = cur_addr | 8'd1;
            end else if (item.event_flags[EV_ADDR_ACKED]) begin
              if (remain_in == 8'd0) begin
                result.set_stop = 1'b1;
                result.txn_end  = END_DONE;
                result.txn_id   = cur_id;
                phase_next      = PH_IDLE;
              end else if (remain_in == 8'd1) begin
                result.ack_ctl  = ACK_DISABLE;
                result.set_stop = 1'b1;
              end else begin
                result.ack_ctl = ACK_ENABLE;
              end
            end else if (item.event_flags[EV_RX_READY] && remain_in != 8'd0) begin
              result.rx_valid = 1'b1;
              result.rx_byte  = item.data;
              remain_in_next  = remain_in - 8'd1;
              if (remain_in == 8'd2) begin
                result.ack_ctl  = ACK_DISABLE;
                result.set_stop = 1'b1;
              end
              if (remain_in == 8'd1) begin
                result.txn_end = END_DONE;
                result.txn_id  = cur_id;
                phase_next     = PH_IDLE;
              end
            end else begin
              // Other events, and a receive event with no byte left, are ignored.
            end
          end
          default: begin
            // No transaction in flight: engine events are ignored.
          end
        endcase
      end
      CMD_ERROR_EVENT: begin
        result.clear_errors = 1'b1;
        if (phase != PH_IDLE) begin
          // Discard the unsent bytes of this transaction that are already queued.
          if (remain_ext < count_ext) begin
            tx_drop = TCW'(remain_out);
          end else begin
            tx_drop = tx_count;
          end
          remain_out_next = 8'd0;
          remain_in_next  = 8'd0;
          result.txn_end  = END_FAIL;
          result.txn_id   = cur_id;
          result.set_stop = 1'b1;
          phase_next      = PH_IDLE;
        end
        if (item.event_flags[EV_BUS_ERROR]) begin
          result.set_stop = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Launch the oldest queued transaction whenever the sequencer is left idle.
    if (phase_next == PH_IDLE && (q_count != '0 || q_op.push)) begin
      if (q_count == '0) begin
        start_entry = q_wr;
      end
      q_op.pop         = 1'b1;
      cur_addr_next    = start_entry.addr;
      remain_out_next  = start_entry.len_out;
      remain_in_next   = start_entry.len_in;
      cur_id_next      = start_entry.id;
      phase_next       = (start_entry.len_out != 8'd0) ? PH_SEND : PH_RECV;
      result.set_start = 1'b1;
    end

    result.phase = phase_next;
  end

  assign q_cmd       = step ? q_op : '0;
  assign tx_cmd      = step ? tx_op : '0;
  assign tx_drop_cmd = step ? tx_drop : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      cur_addr   <= 8'd0;
      remain_out <= 8'd0;
      remain_in  <= 8'd0;
      cur_id     <= 8'd0;
      next_id    <= 8'd0;
    end else if (step) begin
      phase      <= phase_next;
      cur_addr   <= cur_addr_next;
      remain_out <= remain_out_next;
      remain_in  <= remain_in_next;
      cur_id     <= cur_id_next;
      next_id    <= next_id_next;
    end
  end

  i2cseq_fifo #(
    .WIDTH ($bits(txn_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_txn_queue (
    .clk     (clk),
    .rst     (rst),
    .op      (q_cmd),
    .drop    ('0),
    .wr_data (q_wr),
    .count   (q_count),
    .front   (q_front)
  );

  i2cseq_fifo #(
    .WIDTH (8),
    .DEPTH (TX_FIFO_DEPTH)
  ) u_tx_fifo (
    .clk     (clk),
    .rst     (rst),
    .op      (tx_cmd),
    .drop    (tx_drop_cmd),
    .wr_data (item.data),
    .count   (tx_count),
    .front   (tx_front)
  );

`ifndef NO_ASSERTIONS
  a_idle_no_remaining: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> (remain_out == 8'd0 && remain_in == 8'd0))
    else $error("idle with bytes still outstanding");
  a_tx_pop_in_send: assert property (@(posedge clk) disable iff (rst)
    tx_cmd.pop |-> (phase == PH_SEND && item.cmd == CMD_ENGINE_EVENT))
    else $error("byte taken from fifo outside the write phase");
  a_reject_when_full: assert property (@(posedge clk) disable iff (rst)
    (step && result.rejected) |->
      ((item.cmd == CMD_ENQUEUE && q_count == QCW'(QUEUE_DEPTH)) ||
       (item.cmd == CMD_PUSH_BYTE && tx_count == TCW'(TX_FIFO_DEPTH))))
    else $error("beat rejected while its store had room");
`endif

endmodule

`default_nettype wire

FILE: rtl/i2c_master_transaction_sequencer_unit.sv
// I2C master transaction sequencer: queues write-then-read transactions and drives a
// byte-level I2C engine. Depends on i2cseq_pkg and i2cseq_core.
`default_nettype none

// The sequencer takes one beat per clock on its input channel while the consumer takes
// its results, and returns exactly one result beat for each. An input beat is first
// captured in an input register; once the result register is free or being emptied,
// the step logic reads that register together with the transaction state, updates the
// state and loads the result register. The state is updated once per processed beat,
// so the sustained rate is one beat per cycle: a new beat is taken in the same cycle
// in which the previous one is processed, and the input side keeps accepting while a
// finished result waits for the consumer, until both registers are full. Enqueue
// beats append to the transaction queue (QUEUE_DEPTH entries) and return the assigned
// id; push beats append to the outgoing byte FIFO (TX_FIFO_DEPTH bytes). A beat that
// finds its store full is answered with rejected set and changes nothing. Both stores
// sit in registered-read RAMs whose head entry is prefetched every cycle, so a byte or
// transaction written one beat earlier is immediately usable. Whenever the sequencer
// is left idle and a transaction is queued, that transaction starts in the same beat,
// possibly together with the STOP of the one that just ended. No clearing pass is
// needed after reset: the stores are guarded by their fill counts.
module i2c_master_transaction_sequencer_unit
  import i2cseq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int TX_FIFO_DEPTH = TX_FIFO_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire in_item_t  in_item,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_item
);

  logic      held_valid;
  in_item_t  held_item;
  logic      step;
  out_item_t step_result;

  // The held beat is processed when the result register is free or being emptied.
  assign step     = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        held_valid <= in_valid;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
    if (step) begin
      out_item <= step_result;
    end
  end

  i2cseq_core #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .TX_FIFO_DEPTH (TX_FIFO_DEPTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held_item),
    .result (step_result)
  );

`ifndef NO_ASSERTIONS
  a_step_needs_beat: assert property (@(posedge clk) disable iff (rst)
    step |-> held_valid)
    else $error("step without a held beat");
  a_result_after_step: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("processed beat produced no result");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !step)
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
